/* sv/polygon_line_crossing_segment_assert.svh */
// assertion macros used by the polygon line crossing segment controller
`ifndef POLYGON_LINE_CROSSING_SEGMENT_ASSERT_SVH
`define POLYGON_LINE_CROSSING_SEGMENT_ASSERT_SVH

// same-cycle implication, disabled during reset
`define PLCS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("plcs assertion failed");

// next-cycle implication, disabled during reset
`define PLCS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("plcs assertion failed");

`endif

/* sv/plcs_pkg.sv */
// shared constants, command codes and status type of the crossing segment block
package plcs_pkg;

  localparam int COORD_BITS = 32;
  localparam int FRAC_BITS  = 16;
  localparam int KIND_W     = 2;
  localparam int CFG_IDX_W  = 2;

  localparam logic [KIND_W-1:0] KIND_INVALID = 2'd0;
  localparam logic [KIND_W-1:0] KIND_POINT   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_SEGMENT = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_LINE_START_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_START_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_END_X   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_END_Y   = 2'd3;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_MUL_A,
    CMD_MUL_B,
    CMD_CLASS,
    CMD_EDGE_PRIOR,
    CMD_EDGE_CLOSE,
    CMD_AXIS_X,
    CMD_AXIS_Y,
    CMD_STORE,
    CMD_ADVANCE,
    CMD_EMIT
  } cmd_t;

  typedef struct packed {
    logic started;
    logic below_changed;
    logic close_needed;
    logic last;
    logic eng_done;
  } dp_status_t;

endpackage

/* sv/plcs_if.sv */
// vertex and result channel interfaces
interface plcs_in_if #(parameter int W = plcs_pkg::COORD_BITS);
  logic          valid;
  logic          ready;
  logic signed [W-1:0] vertex_x;
  logic signed [W-1:0] vertex_y;
  logic          last_vertex;

  modport source (output valid, output vertex_x, output vertex_y, output last_vertex,
                  input ready);
  modport sink (input valid, input vertex_x, input vertex_y, input last_vertex,
                output ready);
endinterface

interface plcs_out_if #(parameter int W = plcs_pkg::COORD_BITS);
  logic          valid;
  logic          ready;
  logic [plcs_pkg::KIND_W-1:0] kind;
  logic signed [W-1:0] first_x;
  logic signed [W-1:0] first_y;
  logic signed [W-1:0] second_x;
  logic signed [W-1:0] second_y;

  modport source (output valid, output kind, output first_x, output first_y,
                  output second_x, output second_y, input ready);
  modport sink (input valid, input kind, input first_x, input first_y,
                input second_x, input second_y, output ready);
endinterface

/* sv/plcs_dp.sv */
// datapath: line registers, cross product, serial multiply-divide engine, results
module plcs_dp #(
  parameter int C = plcs_pkg::COORD_BITS,
  parameter int F = plcs_pkg::FRAC_BITS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [plcs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [C-1:0]                    cfg_wr_data,
  input  logic signed [C-1:0]             in_vertex_x,
  input  logic signed [C-1:0]             in_vertex_y,
  input  logic                            in_last_vertex,
  input  plcs_pkg::cmd_t                  cmd,
  output plcs_pkg::dp_status_t            st,
  output logic [plcs_pkg::KIND_W-1:0]     out_kind,
  output logic signed [C-1:0]             out_first_x,
  output logic signed [C-1:0]             out_first_y,
  output logic signed [C-1:0]             out_second_x,
  output logic signed [C-1:0]             out_second_y
);

  localparam int D1    = C + 1;
  localparam int PW    = 2 * D1;
  localparam int CW    = 2 * C + 3;
  localparam int NW    = D1 + CW;
  localparam int RW    = CW + 2;
  localparam int CNT_W = $clog2(D1);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(D1 - 1);

  typedef enum logic [1:0] {PH_IDLE, PH_MUL, PH_DIV, PH_FIN} eng_ph_t;

  // line registers
  logic signed [C-1:0] sx_r, sy_r, ex_r, ey_r;
  logic signed [D1-1:0] abx, aby;

  // current vertex
  logic signed [C-1:0]  vx_r, vy_r;
  logic                 last_r;
  logic signed [D1-1:0] dx_r, dy_r;
  logic signed [D1-1:0] mul_a, mul_b;
  logic signed [PW-1:0] prod;
  logic signed [PW-1:0] p1_r, p2_r;
  logic signed [CW-1:0] cq_r;
  logic                 cq_below;

  // polygon state
  logic                 started_r;
  logic [1:0]           count_r;
  logic signed [C-1:0]  head_x_r, head_y_r, prior_x_r, prior_y_r;
  logic signed [CW-1:0] chead_r, cprior_r;
  logic                 head_below_r, prior_below_r;
  logic signed [C-1:0]  found_x_r [2];
  logic signed [C-1:0]  found_y_r [2];

  // edge operands
  logic signed [C-1:0]  epx_r, epy_r, eqx_r, eqy_r;
  logic signed [CW-1:0] edp_r;
  logic signed [CW:0]   eden_r;
  logic signed [C-1:0]  eres_x_r, eres_y_r;

  // engine
  eng_ph_t              eng_ph_r;
  logic                 eng_done_r;
  logic                 axis_r;
  logic [CNT_W-1:0]     cnt_r;
  logic [CW-1:0]        mcand_r;
  logic [CW:0]          dv_r;
  logic [D1-1:0]        mplier_r;
  logic [NW-1:0]        acc_r, acc_nxt;
  logic [RW-1:0]        rem_r, rem_try;
  logic [D1-1:0]        quo_r;
  logic                 neg_r;
  logic signed [C-1:0]  base_r;
  logic                 go, go_y;
  logic signed [D1-1:0] dsel;
  logic [D1-1:0]        dabs;
  logic                 rem_ge;
  logic signed [D1:0]   off, vsum;
  logic                 vovf;
  logic signed [C-1:0]  vsat;

  // result forming
  logic [2:0]           total;
  logic signed [C-1:0]  r0x, r0y, r2x, r2y;

  assign abx = D1'(ex_r) - D1'(sx_r);
  assign aby = D1'(ey_r) - D1'(sy_r);

  // one shared multiplier for both cross product terms
  assign mul_a = (cmd == plcs_pkg::CMD_MUL_A) ? abx : aby;
  assign mul_b = (cmd == plcs_pkg::CMD_MUL_A) ? dy_r : dx_r;
  assign prod  = mul_a * mul_b;

  assign cq_below = cq_r[CW-1] | (cq_r == '0);

  assign st.started       = started_r;
  assign st.below_changed = started_r && (cq_below != prior_below_r);
  assign st.close_needed  = last_r && started_r && (cq_below != head_below_r);
  assign st.last          = last_r;
  assign st.eng_done      = eng_done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sx_r <= '0;
      sy_r <= '0;
      ex_r <= C'(64'(1) << F);
      ey_r <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        plcs_pkg::CFG_LINE_START_X: sx_r <= cfg_wr_data;
        plcs_pkg::CFG_LINE_START_Y: sy_r <= cfg_wr_data;
        plcs_pkg::CFG_LINE_END_X:   ex_r <= cfg_wr_data;
        plcs_pkg::CFG_LINE_END_Y:   ey_r <= cfg_wr_data;
        default: ;
      endcase
    end
  end

  // closing crossing leads, then the stored crossings in stream order
  always_comb begin
    total = {1'b0, count_r} + {2'b00, st.close_needed};
    r0x = '0;
    r0y = '0;
    r2x = '0;
    r2y = '0;
    if (st.close_needed) begin
      r0x = eres_x_r;
      r0y = eres_y_r;
      if (count_r != 2'd0) begin
        r2x = found_x_r[0];
        r2y = found_y_r[0];
      end
    end else begin
      if (count_r != 2'd0) begin
        r0x = found_x_r[0];
        r0y = found_y_r[0];
      end
      if (count_r >= 2'd2) begin
        r2x = found_x_r[1];
        r2y = found_y_r[1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      started_r <= 1'b0;
      count_r   <= '0;
    end else begin
      case (cmd)
        plcs_pkg::CMD_ADVANCE: begin
          started_r <= 1'b1;
        end
        plcs_pkg::CMD_STORE: begin
          if (count_r != 2'd3) count_r <= count_r + 2'd1;
        end
        plcs_pkg::CMD_EMIT: begin
          started_r <= 1'b0;
          count_r   <= '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd)
      plcs_pkg::CMD_LOAD: begin
        vx_r   <= in_vertex_x;
        vy_r   <= in_vertex_y;
        last_r <= in_last_vertex;
        dx_r   <= D1'(in_vertex_x) - D1'(sx_r);
        dy_r   <= D1'(in_vertex_y) - D1'(sy_r);
      end
      plcs_pkg::CMD_MUL_A: p1_r <= prod;
      plcs_pkg::CMD_MUL_B: p2_r <= prod;
      plcs_pkg::CMD_CLASS: cq_r <= CW'(p1_r) - CW'(p2_r);
      plcs_pkg::CMD_EDGE_PRIOR: begin
        epx_r  <= prior_x_r;
        epy_r  <= prior_y_r;
        eqx_r  <= vx_r;
        eqy_r  <= vy_r;
        edp_r  <= cprior_r;
        eden_r <= (CW+1)'(cprior_r) - (CW+1)'(cq_r);
      end
      plcs_pkg::CMD_EDGE_CLOSE: begin
        epx_r  <= vx_r;
        epy_r  <= vy_r;
        eqx_r  <= head_x_r;
        eqy_r  <= head_y_r;
        edp_r  <= cq_r;
        eden_r <= (CW+1)'(cq_r) - (CW+1)'(chead_r);
      end
      plcs_pkg::CMD_STORE: begin
        if (!count_r[1]) begin
          found_x_r[count_r[0]] <= eres_x_r;
          found_y_r[count_r[0]] <= eres_y_r;
        end
      end
      plcs_pkg::CMD_ADVANCE: begin
        prior_x_r     <= vx_r;
        prior_y_r     <= vy_r;
        cprior_r      <= cq_r;
        prior_below_r <= cq_below;
        if (!started_r) begin
          head_x_r     <= vx_r;
          head_y_r     <= vy_r;
          chead_r      <= cq_r;
          head_below_r <= cq_below;
        end
      end
      plcs_pkg::CMD_EMIT: begin
        if (total == 3'd0 || total > 3'd2) begin
          out_kind     <= plcs_pkg::KIND_INVALID;
          out_first_x  <= '0;
          out_first_y  <= '0;
          out_second_x <= '0;
          out_second_y <= '0;
        end else if (total == 3'd1) begin
          out_kind     <= plcs_pkg::KIND_POINT;
          out_first_x  <= r0x;
          out_first_y  <= r0y;
          out_second_x <= '0;
          out_second_y <= '0;
        end else begin
          out_kind     <= plcs_pkg::KIND_SEGMENT;
          out_first_x  <= r0x;
          out_first_y  <= r0y;
          out_second_x <= r2x;
          out_second_y <= r2y;
        end
      end
      default: ;
    endcase
  end

  // engine: |d|*|dp| by shift-add, then restoring divide by |den|
  assign go    = (cmd == plcs_pkg::CMD_AXIS_X) || (cmd == plcs_pkg::CMD_AXIS_Y);
  assign go_y  = (cmd == plcs_pkg::CMD_AXIS_Y);
  assign dsel  = go_y ? (D1'(eqy_r) - D1'(epy_r)) : (D1'(eqx_r) - D1'(epx_r));
  assign dabs  = dsel[D1-1] ? D1'(-dsel) : D1'(dsel);

  assign acc_nxt = {acc_r[NW-2:0], 1'b0} + (mplier_r[D1-1] ? NW'(mcand_r) : NW'(0));
  assign rem_try = {rem_r[RW-2:0], mplier_r[D1-1]};
  assign rem_ge  = rem_try >= RW'(dv_r);

  assign off  = neg_r ? -$signed((D1+1)'(quo_r)) : $signed((D1+1)'(quo_r));
  assign vsum = (D1+1)'(base_r) + off;
  assign vovf = !((&vsum[D1:C-1]) || !(|vsum[D1:C-1]));
  assign vsat = vovf ? {vsum[D1], {(C-1){~vsum[D1]}}} : vsum[C-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eng_ph_r   <= PH_IDLE;
      eng_done_r <= 1'b0;
    end else begin
      eng_done_r <= 1'b0;
      case (eng_ph_r)
        PH_IDLE: begin
          if (go) eng_ph_r <= PH_MUL;
        end
        PH_MUL: begin
          if (cnt_r == CNT_LAST) eng_ph_r <= PH_DIV;
        end
        PH_DIV: begin
          if (cnt_r == CNT_LAST) eng_ph_r <= PH_FIN;
        end
        PH_FIN: begin
          eng_ph_r   <= PH_IDLE;
          eng_done_r <= 1'b1;
        end
        default: eng_ph_r <= PH_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (eng_ph_r)
      PH_IDLE: begin
        if (go) begin
          axis_r   <= go_y;
          base_r   <= go_y ? epy_r : epx_r;
          mplier_r <= dabs;
          mcand_r  <= edp_r[CW-1] ? CW'(-edp_r) : CW'(edp_r);
          dv_r     <= eden_r[CW] ? (CW+1)'(-eden_r) : (CW+1)'(eden_r);
          neg_r    <= dsel[D1-1] ^ edp_r[CW-1] ^ eden_r[CW];
          acc_r    <= '0;
          cnt_r    <= '0;
        end
      end
      PH_MUL: begin
        if (cnt_r == CNT_LAST) begin
          rem_r    <= RW'(acc_nxt[NW-1:D1]);
          mplier_r <= acc_nxt[D1-1:0];
          cnt_r    <= '0;
        end else begin
          acc_r    <= acc_nxt;
          mplier_r <= {mplier_r[D1-2:0], 1'b0};
          cnt_r    <= cnt_r + CNT_W'(1);
        end
      end
      PH_DIV: begin
        rem_r    <= rem_ge ? (rem_try - RW'(dv_r)) : rem_try;
        quo_r    <= {quo_r[D1-2:0], rem_ge};
        mplier_r <= {mplier_r[D1-2:0], 1'b0};
        cnt_r    <= cnt_r + CNT_W'(1);
      end
      PH_FIN: begin
        if (axis_r) eres_y_r <= vsat;
        else        eres_x_r <= vsat;
      end
      default: ;
    endcase
  end

endmodule

/* sv/plcs_ctrl.sv */
// controller: sequences the datapath per vertex and owns the handshakes
`include "polygon_line_crossing_segment_assert.svh"

module plcs_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  plcs_pkg::dp_status_t st,
  output plcs_pkg::cmd_t       cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_MULA, S_MULB, S_CLASS, S_DECIDE, S_EP, S_EC,
    S_GOX, S_WAITX, S_GOY, S_WAITY, S_STORE, S_FIN
  } state_t;

  state_t state_r;
  logic   closing_r;
  logic   out_valid_r;
  logic   out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    case (state_r)
      S_IDLE:  cmd = in_valid ? plcs_pkg::CMD_LOAD : plcs_pkg::CMD_NONE;
      S_MULA:  cmd = plcs_pkg::CMD_MUL_A;
      S_MULB:  cmd = plcs_pkg::CMD_MUL_B;
      S_CLASS: cmd = plcs_pkg::CMD_CLASS;
      S_EP:    cmd = plcs_pkg::CMD_EDGE_PRIOR;
      S_EC:    cmd = plcs_pkg::CMD_EDGE_CLOSE;
      S_GOX:   cmd = plcs_pkg::CMD_AXIS_X;
      S_GOY:   cmd = plcs_pkg::CMD_AXIS_Y;
      S_STORE: cmd = plcs_pkg::CMD_STORE;
      S_FIN: begin
        if (!st.last)     cmd = plcs_pkg::CMD_ADVANCE;
        else if (out_free) cmd = plcs_pkg::CMD_EMIT;
        else              cmd = plcs_pkg::CMD_NONE;
      end
      default: cmd = plcs_pkg::CMD_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      closing_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd == plcs_pkg::CMD_EMIT) out_valid_r <= 1'b1;
      else if (out_ready)            out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE:   if (in_valid) state_r <= S_MULA;
        S_MULA:   state_r <= S_MULB;
        S_MULB:   state_r <= S_CLASS;
        S_CLASS:  state_r <= S_DECIDE;
        S_DECIDE: begin
          if (st.below_changed) begin
            state_r   <= S_EP;
            closing_r <= 1'b0;
          end else if (st.close_needed) begin
            state_r   <= S_EC;
            closing_r <= 1'b1;
          end else begin
            state_r <= S_FIN;
          end
        end
        S_EP:     state_r <= S_GOX;
        S_EC:     state_r <= S_GOX;
        S_GOX:    state_r <= S_WAITX;
        S_WAITX:  if (st.eng_done) state_r <= S_GOY;
        S_GOY:    state_r <= S_WAITY;
        S_WAITY:  if (st.eng_done) state_r <= closing_r ? S_FIN : S_STORE;
        S_STORE: begin
          if (st.close_needed) begin
            state_r   <= S_EC;
            closing_r <= 1'b1;
          end else begin
            state_r <= S_FIN;
          end
        end
        S_FIN:    if (!st.last || out_free) state_r <= S_IDLE;
        default:  state_r <= S_IDLE;
      endcase
    end
  end

  `PLCS_ASSERT_IMP(a_done_only_waiting, clk, rst_n, st.eng_done, (state_r == S_WAITX) || (state_r == S_WAITY))
  `PLCS_ASSERT_NXT(a_emit_raises_valid, clk, rst_n, cmd == plcs_pkg::CMD_EMIT, out_valid_r)
  `PLCS_ASSERT_IMP(a_valid_from_emit, clk, rst_n, $rose(out_valid_r), $past(cmd == plcs_pkg::CMD_EMIT))

endmodule

/* sv/polygon_line_crossing_segment.sv */
// polygon line crossing segment: top level joining controller and datapath
// Vertices of a closed polygon arrive one transfer at a time, the last one
// flagged; each is classed against the configured line by the sign of a cross
// product (on the line counts as below). Every edge whose ends differ in class
// gives a crossing point, and when the last vertex arrives the closing edge is
// tested too and its crossing leads. One result transfer follows each polygon:
// kind invalid (no crossing or more than two), point or segment. Each
// crossing edge is worked out by the shared bit-serial multiply-divide
// engine, one axis at a time, and a vertex is taken in only when the
// previous one is done. A result may wait at the output while further
// vertices are taken in; only a last vertex waits for the slot.
// The line registers may be written only while no polygon is in flight.
module polygon_line_crossing_segment #(
  parameter int COORD_BITS = plcs_pkg::COORD_BITS,
  parameter int FRAC_BITS  = plcs_pkg::FRAC_BITS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  plcs_in_if.sink                        in_ch,
  plcs_out_if.source                     out_ch,
  input  logic                           cfg_wr_en,
  input  logic [plcs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [COORD_BITS-1:0]          cfg_wr_data
);

  // command and status between the sequencer and the arithmetic
  plcs_pkg::cmd_t       cmd;
  plcs_pkg::dp_status_t st;

  plcs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .st        (st),
    .cmd       (cmd)
  );

  // result payload is held in datapath registers until the transfer
  plcs_dp #(
    .C (COORD_BITS),
    .F (FRAC_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_wr_data    (cfg_wr_data),
    .in_vertex_x    (in_ch.vertex_x),
    .in_vertex_y    (in_ch.vertex_y),
    .in_last_vertex (in_ch.last_vertex),
    .cmd            (cmd),
    .st             (st),
    .out_kind       (out_ch.kind),
    .out_first_x    (out_ch.first_x),
    .out_first_y    (out_ch.first_y),
    .out_second_x   (out_ch.second_x),
    .out_second_y   (out_ch.second_y)
  );

endmodule
